### design/seig_pkg.sv
`default_nettype none

package seig_pkg;

    localparam int DATA_BITS     = 32;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_BITS    = 60 - DATA_BITS;
    localparam int EIG_BITS      = DATA_BITS + 2;
    localparam int ANGLE_BITS    = 17;
    localparam int CW            = 64;
    localparam int ZW            = 33;
    localparam int PROD_BITS     = 62;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    typedef logic signed [DATA_BITS-1:0]  t_data;
    typedef logic signed [CW-1:0]         t_vec;
    typedef logic signed [ZW-1:0]         t_ang;
    typedef logic signed [EIG_BITS-1:0]   t_eig;
    typedef logic signed [ANGLE_BITS-1:0] t_angle;

    typedef struct packed {
        logic   special;
        t_eig   sp_major;
        t_eig   sp_minor;
        t_angle sp_angle;
        t_eig   s1;
        logic   last;
    } t_side;

    localparam t_angle ANG_ZERO    = 17'sd0;
    localparam t_angle ANG_HALF_PI = 17'sd32768;
    localparam t_angle ANG_QTR_POS = 17'sd16384;
    localparam t_angle ANG_QTR_NEG = -17'sd16384;

    localparam t_ang Z_HALF_PI = 33'sd1073741824;

    function automatic logic [ZW-1:0] atan_q31(input int idx);
        logic [ZW-1:0] v;
        case (idx)
            0:       v = 33'd536870912;
            1:       v = 33'd316933406;
            2:       v = 33'd167458907;
            3:       v = 33'd85004756;
            4:       v = 33'd42667331;
            5:       v = 33'd21354465;
            6:       v = 33'd10679838;
            7:       v = 33'd5340245;
            8:       v = 33'd2670163;
            9:       v = 33'd1335087;
            10:      v = 33'd667544;
            11:      v = 33'd333772;
            12:      v = 33'd166886;
            13:      v = 33'd83443;
            14:      v = 33'd41722;
            15:      v = 33'd20861;
            16:      v = 33'd10430;
            17:      v = 33'd5215;
            18:      v = 33'd2608;
            19:      v = 33'd1304;
            20:      v = 33'd652;
            21:      v = 33'd326;
            22:      v = 33'd163;
            23:      v = 33'd81;
            24:      v = 33'd41;
            25:      v = 33'd20;
            26:      v = 33'd10;
            27:      v = 33'd5;
            28:      v = 33'd3;
            29:      v = 33'd1;
            30:      v = 33'd1;
            default: v = 33'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/seig_if.sv
`default_nettype none

interface seig_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [seig_pkg::DATA_BITS-1:0] a_xx;
    logic signed [seig_pkg::DATA_BITS-1:0] a_xy;
    logic signed [seig_pkg::DATA_BITS-1:0] a_yy;
    logic                           last_in;

    modport source (output valid, a_xx, a_xy, a_yy, last_in, input ready);
    modport sink (input valid, a_xx, a_xy, a_yy, last_in, output ready);
endinterface

interface seig_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [seig_pkg::EIG_BITS-1:0]   eig_major;
    logic signed [seig_pkg::EIG_BITS-1:0]   eig_minor;
    logic signed [seig_pkg::ANGLE_BITS-1:0] angle;
    logic                                   last_out;

    modport source (output valid, eig_major, eig_minor, angle, last_out, input ready);
    modport sink (input valid, eig_major, eig_minor, angle, last_out, output ready);
endinterface

`default_nettype wire

### design/symmetric2x2_eigen_decompose_core.sv
// The pipeline from an accepted input word to its result word has one setup stage,
// one stage per CORDIC iteration (16) and three gain and rounding stages.
// Throughput is one word per cycle; the whole pipeline holds while a result waits.
// Reset is synchronous and active low; it clears only the valid bits of the pipeline.
`default_nettype none

module symmetric2x2_eigen_decompose_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    seig_in_if.sink    i_in,
    seig_out_if.source o_out
);
    import seig_pkg::*;

    logic  w_en;
    logic  w_pre_vld;
    t_vec  w_pre_x;
    t_vec  w_pre_y;
    t_ang  w_pre_z;
    t_side w_pre_side;
    logic  w_cor_vld;
    t_vec  w_cor_x;
    t_ang  w_cor_z;
    t_side w_cor_side;
    logic  w_out_vld;

    assign w_en       = !w_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    seig_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_a_xx  (i_in.a_xx),
        .i_a_xy  (i_in.a_xy),
        .i_a_yy  (i_in.a_yy),
        .i_last  (i_in.last_in),
        .o_valid (w_pre_vld),
        .o_x     (w_pre_x),
        .o_y     (w_pre_y),
        .o_z     (w_pre_z),
        .o_side  (w_pre_side)
    );

    seig_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pre_vld),
        .i_x     (w_pre_x),
        .i_y     (w_pre_y),
        .i_z     (w_pre_z),
        .i_side  (w_pre_side),
        .o_valid (w_cor_vld),
        .o_x     (w_cor_x),
        .o_z     (w_cor_z),
        .o_side  (w_cor_side)
    );

    seig_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cor_vld),
        .i_x     (w_cor_x),
        .i_z     (w_cor_z),
        .i_side  (w_cor_side),
        .o_valid (w_out_vld),
        .o_major (o_out.eig_major),
        .o_minor (o_out.eig_minor),
        .o_angle (o_out.angle),
        .o_last  (o_out.last_out)
    );

    assign o_out.valid = w_out_vld;

endmodule

`default_nettype wire

### design/seig_pre.sv
`default_nettype none

module seig_pre (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  seig_pkg::t_data i_a_xx,
    input  seig_pkg::t_data i_a_xy,
    input  seig_pkg::t_data i_a_yy,
    input  logic            i_last,
    output logic            o_valid,
    output seig_pkg::t_vec  o_x,
    output seig_pkg::t_vec  o_y,
    output seig_pkg::t_ang  o_z,
    output seig_pkg::t_side o_side
);
    import seig_pkg::*;

    logic signed [DATA_BITS:0] w_dxy;
    logic signed [DATA_BITS:0] w_dyx;
    t_vec  w_xp;
    t_vec  w_xr;
    t_vec  w_y2;
    t_vec  w_yn;
    t_eig  w_xx_p_xy;
    t_eig  w_xx_m_xy;
    logic  w_x_neg;
    logic  w_off_zero;
    logic  w_diag_eq;
    t_vec  n_x;
    t_vec  n_y;
    t_ang  n_z;
    t_side n_side;
    logic  r_valid;
    t_vec  r_x;
    t_vec  r_y;
    t_ang  r_z;
    t_side r_side;

    assign w_dxy      = {i_a_xx[DATA_BITS-1], i_a_xx} - {i_a_yy[DATA_BITS-1], i_a_yy};
    assign w_dyx      = {i_a_yy[DATA_BITS-1], i_a_yy} - {i_a_xx[DATA_BITS-1], i_a_xx};
    assign w_xp       = t_vec'(w_dxy) <<< GUARD_BITS;
    assign w_xr       = t_vec'(w_dyx) <<< GUARD_BITS;
    assign w_y2       = t_vec'(i_a_xy) <<< (GUARD_BITS + 1);
    assign w_yn       = -w_y2;
    assign w_xx_p_xy  = t_eig'(i_a_xx) + t_eig'(i_a_xy);
    assign w_xx_m_xy  = t_eig'(i_a_xx) - t_eig'(i_a_xy);
    assign w_x_neg    = i_a_xx < i_a_yy;
    assign w_off_zero = i_a_xy == '0;
    assign w_diag_eq  = i_a_xx == i_a_yy;

    always_comb begin
        if (!w_x_neg) begin
            n_x = w_xp;
            n_y = w_yn;
            n_z = '0;
        end else if (i_a_xy[DATA_BITS-1]) begin
            n_x = w_yn;
            n_y = w_xr;
            n_z = Z_HALF_PI;
        end else begin
            n_x = w_y2;
            n_y = w_xp;
            n_z = -Z_HALF_PI;
        end

        n_side.special = w_off_zero | w_diag_eq;
        n_side.s1      = t_eig'(i_a_xx) + t_eig'(i_a_yy) + t_eig'(1);
        n_side.last    = i_last;
        if (w_off_zero) begin
            if (!w_x_neg) begin
                n_side.sp_major = t_eig'(i_a_xx);
                n_side.sp_minor = t_eig'(i_a_yy);
                n_side.sp_angle = ANG_ZERO;
            end else begin
                n_side.sp_major = t_eig'(i_a_yy);
                n_side.sp_minor = t_eig'(i_a_xx);
                n_side.sp_angle = ANG_HALF_PI;
            end
        end else if (!i_a_xy[DATA_BITS-1]) begin
            n_side.sp_major = w_xx_p_xy;
            n_side.sp_minor = w_xx_m_xy;
            n_side.sp_angle = ANG_QTR_NEG;
        end else begin
            n_side.sp_major = w_xx_m_xy;
            n_side.sp_minor = w_xx_p_xy;
            n_side.sp_angle = ANG_QTR_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

### design/seig_cordic.sv
`default_nettype none

module seig_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  seig_pkg::t_vec  i_x,
    input  seig_pkg::t_vec  i_y,
    input  seig_pkg::t_ang  i_z,
    input  seig_pkg::t_side i_side,
    output logic            o_valid,
    output seig_pkg::t_vec  o_x,
    output seig_pkg::t_ang  o_z,
    output seig_pkg::t_side o_side
);
    import seig_pkg::*;

    logic  r_vld  [CORDIC_STAGES];
    t_vec  r_x    [CORDIC_STAGES];
    t_vec  r_y    [CORDIC_STAGES];
    t_ang  r_z    [CORDIC_STAGES];
    t_side r_side [CORDIC_STAGES];

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        localparam t_ang ATAN_G = t_ang'(atan_q31(g));
        logic  w_vin;
        t_vec  w_xin;
        t_vec  w_yin;
        t_ang  w_zin;
        t_side w_sin;
        t_vec  w_xs;
        t_vec  w_ys;

        if (g == 0) begin : g_first
            assign w_vin = i_valid;
            assign w_xin = i_x;
            assign w_yin = i_y;
            assign w_zin = i_z;
            assign w_sin = i_side;
        end else begin : g_next
            assign w_vin = r_vld[g-1];
            assign w_xin = r_x[g-1];
            assign w_yin = r_y[g-1];
            assign w_zin = r_z[g-1];
            assign w_sin = r_side[g-1];
        end

        assign w_xs = w_xin >>> g;
        assign w_ys = w_yin >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= w_sin;
                if (!w_yin[CW-1]) begin
                    r_x[g] <= w_xin + w_ys;
                    r_y[g] <= w_yin - w_xs;
                    r_z[g] <= w_zin + ATAN_G;
                end else begin
                    r_x[g] <= w_xin - w_ys;
                    r_y[g] <= w_yin + w_xs;
                    r_z[g] <= w_zin - ATAN_G;
                end
            end
        end
    end

    assign o_valid = r_vld[CORDIC_STAGES-1];
    assign o_x     = r_x[CORDIC_STAGES-1];
    assign o_z     = r_z[CORDIC_STAGES-1];
    assign o_side  = r_side[CORDIC_STAGES-1];

endmodule

`default_nettype wire

### design/seig_post.sv
`default_nettype none

module seig_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  seig_pkg::t_vec     i_x,
    input  seig_pkg::t_ang     i_z,
    input  seig_pkg::t_side    i_side,
    output logic               o_valid,
    output seig_pkg::t_eig     o_major,
    output seig_pkg::t_eig     o_minor,
    output seig_pkg::t_angle   o_angle,
    output logic               o_last
);
    import seig_pkg::*;

    localparam logic signed [ZW-16:0] AR_HALF = (ZW-15)'(32768);
    localparam logic signed [ZW-16:0] AR_FULL = (ZW-15)'(65536);

    t_ang                    w_za;
    logic signed [ZW-16:0]   w_ar;
    logic signed [ZW-16:0]   w_wrap;
    t_vec                    w_base;
    t_vec                    w_num_major;
    t_vec                    w_num_minor;
    logic [CW-1:0]           n_dq;

    logic                    r_a_vld;
    logic [PROD_BITS-1:0]    r_phi;
    logic [PROD_BITS-1:0]    r_plo;
    logic signed [ZW-16:0]   r_a_ar;
    t_side                   r_a_side;

    logic                    r_b_vld;
    logic [CW-1:0]           r_dq;
    t_angle                  r_b_ang;
    t_side                   r_b_side;

    logic                    r_c_vld;
    t_eig                    r_major;
    t_eig                    r_minor;
    t_angle                  r_angle;
    logic                    r_last;

    assign w_za = i_z + t_ang'(32768);
    assign w_ar = {w_za[ZW-1], w_za[ZW-1:16]};

    always_comb begin
        if (r_a_ar > AR_HALF) begin
            w_wrap = r_a_ar - AR_FULL;
        end else if (r_a_ar <= -AR_HALF) begin
            w_wrap = r_a_ar + AR_FULL;
        end else begin
            w_wrap = r_a_ar;
        end
    end

    assign n_dq        = {r_phi, 2'b00} + CW'(r_plo[PROD_BITS-1:30]);
    assign w_base      = t_vec'(r_b_side.s1) <<< GUARD_BITS;
    assign w_num_major = w_base + t_vec'(r_dq);
    assign w_num_minor = w_base - t_vec'(r_dq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phi    <= i_x[CW-1:32] * INV_GAIN_Q30;
            r_plo    <= i_x[31:0] * INV_GAIN_Q30;
            r_a_ar   <= w_ar;
            r_a_side <= i_side;

            r_dq     <= n_dq;
            r_b_ang  <= t_angle'(w_wrap[ANGLE_BITS-1:0]);
            r_b_side <= r_a_side;

            r_last   <= r_b_side.last;
            if (r_b_side.special) begin
                r_major <= r_b_side.sp_major;
                r_minor <= r_b_side.sp_minor;
                r_angle <= r_b_side.sp_angle;
            end else begin
                r_major <= t_eig'(w_num_major[GUARD_BITS+EIG_BITS:GUARD_BITS+1]);
                r_minor <= t_eig'(w_num_minor[GUARD_BITS+EIG_BITS:GUARD_BITS+1]);
                r_angle <= r_b_ang;
            end
        end
    end

    assign o_valid = r_c_vld;
    assign o_major = r_major;
    assign o_minor = r_minor;
    assign o_angle = r_angle;
    assign o_last  = r_last;

endmodule

`default_nettype wire
